@@ rtl/assert_macros.svh @@
// assertion helpers for the rtl, clocked by clk and held off in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mtt_pkg.sv @@
package mtt_pkg;

    // table geometry
    localparam int SLOTS    = 16;
    localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_W   = 4;
    localparam int MSG_W    = 32;
    localparam int TICK_W   = 32;
    localparam int PERIOD_W = 28;
    localparam int TASK_W   = 8;

    // period = ms / 30 computed as ((ms >> 1) * RECIP) >> SHIFT
    localparam logic [31:0] TICK_RECIP = 32'd2290649225;
    localparam int          TICK_SHIFT = 35;
    localparam int          PROD_W     = 63;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_CREATE = 2'd1,
        CMD_CANCEL = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_CREATED   = 3'd0,
        KIND_FULL      = 3'd1,
        KIND_CANCELLED = 3'd2,
        KIND_NOTFOUND  = 3'd3,
        KIND_EXPIRED   = 3'd4,
        KIND_CLEARED   = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_FLUSH
    } state_t;

    // one timer entry as held in the slot memory
    typedef struct packed {
        logic [MSG_W-1:0]    message;
        logic [TICK_W-1:0]   match;
        logic [PERIOD_W-1:0] period;
        logic                rep;
        logic [TASK_W-1:0]   task_id;
    } slot_entry_t;

    // one result word
    typedef struct packed {
        kind_t               kind;
        logic [SLOT_W-1:0]   slot;
        logic [MSG_W-1:0]    message;
        logic [TASK_W-1:0]   task_id;
    } result_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    // low bits of a slot index as carried in the result
    function automatic logic [SLOT_W-1:0] slot_field(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, idx};
        return wide[SLOT_W-1:0];
    endfunction

endpackage

@@ rtl/mtt_ram.sv @@
module mtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/mtt_period.sv @@
module mtt_period
    import mtt_pkg::*;
(
    input  logic                clk,
    input  logic                load,
    input  logic [31:0]         period_ms,
    output logic [PERIOD_W-1:0] period
);

    logic [31:0]         ms_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [PERIOD_W-1:0] quot;

    // capture the requested milliseconds with the command
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ms_reg <= period_ms;
        end
    end

    // divide by 30: halve, then multiply by the reciprocal of 15
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(ms_reg[31:1]) * PROD_W'(TICK_RECIP);
    end

    // quotient, held at a minimum of one tick
    assign quot   = prod_reg[TICK_SHIFT +: PERIOD_W];
    assign period = (quot == '0) ? PERIOD_W'(1) : quot;

endmodule

@@ rtl/message_timer_table_unit.sv @@
// a tick scans every slot; a create scans to the first free slot and writes it, or scans
// every slot when the table is full; a cancel scans to the first match; a clear does no scan
// the last result of a command reaches the output in the same cycle that the next can enter
// one command at a time; the scan over the slot memory read port sets the rate
// results wait in a one-word output register, so a stalled sink holds the scan
// reset: all slots free, tick count zero, no result pending; slot memory is not cleared
`include "assert_macros.svh"

module message_timer_table_unit
    import mtt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // message[31:0], period_ms[63:32], repeat_req[64],
                                   // task_id[72:65], zero pad
    input  logic [1:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // slot[3:0], out_message[35:4], out_task[43:36], zero pad
    output logic [2:0]  m_tuser,   // result_kind
    output logic        m_tlast    // last
);

    state_t              state_reg, state_next;
    cmd_t                cmd_reg;
    cmd_t                s_cmd;
    logic [MSG_W-1:0]    msg_reg;
    logic                rep_reg;
    logic [TASK_W-1:0]   task_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [SLOTS-1:0]    valid_reg;
    logic [TICK_W-1:0]   tick_reg;
    logic                pend_valid_reg;
    result_t             pend_reg;
    logic                out_valid_reg;
    result_t             out_reg;
    logic                out_last_reg;

    logic                s_accept;
    logic                out_free;
    logic [PERIOD_W-1:0] period;
    logic [ENTRY_W-1:0]  rdata;
    slot_entry_t         rd_entry;
    slot_entry_t         wr_entry;
    logic [IDX_W-1:0]    raddr;
    logic                mem_we;
    logic                hit_tick;
    logic                hit_cancel;
    logic                last_idx;

    logic                advance;
    logic                capture;
    result_t             capture_res;
    logic                push_pend;
    logic                push_last;
    logic                set_bit;
    logic                clr_bit;
    logic                pend_valid_next;

    assign s_cmd    = cmd_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // period unit
    mtt_period u_period (
        .clk       (clk),
        .load      (s_accept),
        .period_ms (s_tdata[63:32]),
        .period    (period)
    );

    // slot memory
    mtt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (mem_we),
        .waddr (idx_reg),
        .wdata (wr_entry),
        .raddr (raddr),
        .rdata (rdata)
    );

    // slot under scan
    assign rd_entry   = slot_entry_t'(rdata);
    assign hit_tick   = valid_reg[idx_reg] && (rd_entry.match == tick_reg);
    assign hit_cancel = valid_reg[idx_reg] && (rd_entry.message == msg_reg);
    assign last_idx   = (idx_reg == IDX_W'(SLOTS - 1));

    // read the next slot once this one is done, otherwise hold
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            raddr = '0;
        end
        else if (advance)
        begin
            raddr = idx_reg + 1'b1;
        end
        else
        begin
            raddr = idx_reg;
        end
    end

    // datapath control per state
    always_comb
    begin
        advance     = 1'b0;
        capture     = 1'b0;
        capture_res = '{kind: KIND_CLEARED, slot: '0, message: '0, task_id: '0};
        push_pend   = 1'b0;
        push_last   = 1'b0;
        set_bit     = 1'b0;
        clr_bit     = 1'b0;
        mem_we      = 1'b0;
        wr_entry    = rd_entry;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_SCAN:
            begin
                unique case (cmd_reg)
                    CMD_TICK:
                    begin
                        if (!hit_tick)
                        begin
                            advance = 1'b1;
                        end
                        else if (!pend_valid_reg || out_free)
                        begin
                            advance     = 1'b1;
                            push_pend   = pend_valid_reg;
                            capture     = 1'b1;
                            capture_res = '{kind: KIND_EXPIRED, slot: slot_field(idx_reg),
                                            message: rd_entry.message,
                                            task_id: rd_entry.task_id};
                            if (rd_entry.rep)
                            begin
                                mem_we         = 1'b1;
                                wr_entry.match = tick_reg + TICK_W'(rd_entry.period);
                            end
                            else
                            begin
                                clr_bit = 1'b1;
                            end
                        end
                    end
                    CMD_CREATE:
                    begin
                        if (valid_reg[idx_reg])
                        begin
                            if (last_idx)
                            begin
                                capture     = 1'b1;
                                capture_res = '{kind: KIND_FULL, slot: '0, message: '0,
                                                task_id: '0};
                            end
                            else
                            begin
                                advance = 1'b1;
                            end
                        end
                    end
                    CMD_CANCEL:
                    begin
                        if (hit_cancel)
                        begin
                            clr_bit     = 1'b1;
                            capture     = 1'b1;
                            capture_res = '{kind: KIND_CANCELLED, slot: slot_field(idx_reg),
                                            message: msg_reg, task_id: '0};
                        end
                        else if (last_idx)
                        begin
                            capture     = 1'b1;
                            capture_res = '{kind: KIND_NOTFOUND, slot: '0, message: '0,
                                            task_id: '0};
                        end
                        else
                        begin
                            advance = 1'b1;
                        end
                    end
                    CMD_CLEAR:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_WRITE:
            begin
                mem_we      = 1'b1;
                set_bit     = 1'b1;
                wr_entry    = '{message: msg_reg, match: tick_reg + TICK_W'(period),
                                period: period, rep: rep_reg, task_id: task_reg};
                capture     = 1'b1;
                capture_res = '{kind: KIND_CREATED, slot: slot_field(idx_reg),
                                message: msg_reg, task_id: '0};
            end
            ST_FLUSH:
            begin
                push_pend = out_free;
                push_last = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign pend_valid_next = capture || (pend_valid_reg && !push_pend);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = (s_cmd == CMD_CLEAR) ? ST_FLUSH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                unique case (cmd_reg)
                    CMD_TICK:
                    begin
                        if (advance && last_idx)
                        begin
                            state_next = pend_valid_next ? ST_FLUSH : ST_IDLE;
                        end
                    end
                    CMD_CREATE:
                    begin
                        if (!valid_reg[idx_reg])
                        begin
                            state_next = ST_WRITE;
                        end
                        else if (last_idx)
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                    CMD_CANCEL:
                    begin
                        if (hit_cancel || last_idx)
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        state_next = ST_IDLE;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_WRITE:
            begin
                state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cmd_reg        <= CMD_TICK;
            idx_reg        <= '0;
            valid_reg      <= '0;
            tick_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // command capture and tick count
            if (s_accept)
            begin
                cmd_reg <= s_cmd;
                idx_reg <= '0;
                if (s_cmd == CMD_TICK)
                begin
                    tick_reg <= tick_reg + 1'b1;
                end
                else if (s_cmd == CMD_CLEAR)
                begin
                    tick_reg <= '0;
                end
            end
            else if (advance)
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            // slot valid bits
            if (s_accept && (s_cmd == CMD_CLEAR))
            begin
                valid_reg <= '0;
            end
            else if (set_bit)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
            else if (clr_bit)
            begin
                valid_reg[idx_reg] <= 1'b0;
            end

            // pending result
            if (s_accept && (s_cmd == CMD_CLEAR))
            begin
                pend_valid_reg <= 1'b1;
            end
            else
            begin
                pend_valid_reg <= pend_valid_next;
            end

            // output word
            if (push_pend)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            msg_reg  <= s_tdata[31:0];
            rep_reg  <= s_tdata[64];
            task_reg <= s_tdata[72:65];
        end

        if (s_accept && (s_cmd == CMD_CLEAR))
        begin
            pend_reg <= '{kind: KIND_CLEARED, slot: '0, message: '0, task_id: '0};
        end
        else if (capture)
        begin
            pend_reg <= capture_res;
        end

        if (push_pend)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= push_last;
        end
    end

    // output port
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.task_id, out_reg.message, out_reg.slot};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_last_reg;

    `ASSERT_IMPL(a_idle_no_pend, state_reg == ST_IDLE, !pend_valid_reg, "result left pending in idle")
    `ASSERT_IMPL(a_flush_has_pend, state_reg == ST_FLUSH, pend_valid_reg, "flush without a result")
    `ASSERT_NEXT(a_tick_count, s_accept && s_cmd == CMD_TICK, tick_reg == $past(tick_reg) + 32'd1, "tick count did not advance")
    `ASSERT_NEXT(a_clear_table, s_accept && s_cmd == CMD_CLEAR, valid_reg == '0 && tick_reg == '0, "clear left state behind")

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top
    import mtt_pkg::*;
();

    localparam int NUM_SLOTS    = SLOTS;
    localparam int POOL_SIZE    = 8;
    localparam int RAND_WORDS   = 85;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 4000;
    localparam int MAX_REPORTS  = 10;

    // one command word as offered on the input side
    typedef struct {
        cmd_t        cmd;
        logic [31:0] message;
        logic [31:0] period_ms;
        logic        rep;
        logic [7:0]  task_id;
    } timer_cmd_t;

    // one result word as it should come out
    typedef struct {
        kind_t       kind;
        logic [3:0]  slot;
        logic [31:0] message;
        logic [7:0]  task_id;
        logic        last;
    } timer_event_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;   // message[31:0], period_ms[63:32], repeat_req[64],
                                  // task_id[72:65], zero pad
    logic [1:0]  s_tuser  = CMD_TICK;   // cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // slot[3:0], out_message[35:4], out_task[43:36], zero pad
    logic [2:0]  m_tuser;         // result_kind
    logic        m_tlast;

    // shadow copy of the timer table
    logic        busy       [NUM_SLOTS] = '{default: 1'b0};
    logic [31:0] msg_mem    [NUM_SLOTS];
    logic [31:0] match_mem  [NUM_SLOTS];
    logic [27:0] period_mem [NUM_SLOTS];
    logic        rep_mem    [NUM_SLOTS];
    logic [7:0]  task_mem   [NUM_SLOTS];
    logic [31:0] tick_now = '0;

    timer_cmd_t   cmd_queue[$];
    timer_event_t expected_events[$];
    timer_cmd_t   next_cmd;
    timer_cmd_t   accepted;
    timer_event_t want;
    logic [31:0]  msg_pool [POOL_SIZE];

    logic in_fire       = 1'b0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_reqs     = 0;
    int   hold_served   = 0;
    int   hold_left     = 0;
    int   mismatches    = 0;
    int   idle_cycles   = 0;

    message_timer_table_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 clk = ~clk;

    // apply one accepted command to the shadow table and queue its results
    function automatic void advance_timer_table(input timer_cmd_t c);
        logic [NUM_SLOTS-1:0] hit;
        int                   found;
        int                   last_hit;
        logic [31:0]          per;
        timer_event_t         ev;
        ev = '{kind: KIND_CLEARED, slot: 4'd0, message: 32'd0, task_id: 8'd0, last: 1'b1};
        found = -1;
        last_hit = -1;
        case (c.cmd)
            CMD_TICK:
            begin
                tick_now = tick_now + 32'd1;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    hit[i] = busy[i] && (match_mem[i] == tick_now);
                    if (hit[i])
                        last_hit = i;
                end
                // expiries in slot order, last flag on the final one
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (hit[i])
                    begin
                        ev.kind    = KIND_EXPIRED;
                        ev.slot    = 4'(i);
                        ev.message = msg_mem[i];
                        ev.task_id = task_mem[i];
                        ev.last    = (i == last_hit);
                        expected_events.push_back(ev);
                        if (rep_mem[i])
                            match_mem[i] = tick_now + {4'd0, period_mem[i]};
                        else
                            busy[i] = 1'b0;
                    end
                end
            end
            CMD_CREATE:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (!busy[i] && found < 0)
                        found = i;
                if (found < 0)
                begin
                    ev.kind = KIND_FULL;
                end
                else
                begin
                    // period in ticks, never below one
                    per = c.period_ms / 32'd30;
                    if (per == 32'd0)
                        per = 32'd1;
                    busy[found]       = 1'b1;
                    msg_mem[found]    = c.message;
                    period_mem[found] = per[27:0];
                    match_mem[found]  = tick_now + per;
                    rep_mem[found]    = c.rep;
                    task_mem[found]   = c.task_id;
                    ev.kind    = KIND_CREATED;
                    ev.slot    = 4'(found);
                    ev.message = c.message;
                end
                expected_events.push_back(ev);
            end
            CMD_CANCEL:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (busy[i] && msg_mem[i] == c.message && found < 0)
                        found = i;
                if (found < 0)
                begin
                    ev.kind = KIND_NOTFOUND;
                end
                else
                begin
                    busy[found] = 1'b0;
                    ev.kind    = KIND_CANCELLED;
                    ev.slot    = 4'(found);
                    ev.message = c.message;
                end
                expected_events.push_back(ev);
            end
            default:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    busy[i] = 1'b0;
                tick_now = 32'd0;
                expected_events.push_back(ev);
            end
        endcase
    endfunction

    function automatic timer_cmd_t make_cmd(input cmd_t cmd, input logic [31:0] message,
                                            input logic [31:0] period_ms, input logic rep,
                                            input logic [7:0] task_id);
        timer_cmd_t c;
        c.cmd       = cmd;
        c.message   = message;
        c.period_ms = period_ms;
        c.rep       = rep;
        c.task_id   = task_id;
        return c;
    endfunction

    // mostly ticks and creates with short periods, cancels aimed at known messages
    function automatic timer_cmd_t random_timer_cmd();
        timer_cmd_t c;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 50)
            c.cmd = CMD_TICK;
        else if (pick < 75)
            c.cmd = CMD_CREATE;
        else if (pick < 97)
            c.cmd = CMD_CANCEL;
        else
            c.cmd = CMD_CLEAR;
        if ($urandom_range(99) < 65)
            c.message = msg_pool[$urandom_range(POOL_SIZE - 1)];
        else
            c.message = $urandom;
        pick = $urandom_range(99);
        if (pick < 80)
            c.period_ms = $urandom_range(300);
        else if (pick < 95)
            c.period_ms = $urandom_range(3000);
        else
            c.period_ms = $urandom;
        c.rep     = 1'($urandom_range(1));
        c.task_id = 8'($urandom_range(255));
        return c;
    endfunction

    // wait for the input side to empty, then for every result to come back
    task automatic drain_and_wait();
        do @(posedge clk); while (cmd_queue.size() != 0 || s_tvalid);
        do @(negedge clk); while (expected_events.size() != 0);
        @(posedge clk);
    endtask

    // input driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || in_fire)
        begin
            if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_cmd = cmd_queue.pop_front();
                s_tdata  <= {7'd0, next_cmd.task_id, next_cmd.rep,
                             next_cmd.period_ms, next_cmd.message};
                s_tuser  <= next_cmd.cmd;
                s_tvalid <= 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output ready, with a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (hold_served != hold_reqs)
        begin
            hold_served <= hold_reqs;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // predict on accepted command words, check accepted result words
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                accepted.cmd       = cmd_t'(s_tuser);
                accepted.message   = s_tdata[31:0];
                accepted.period_ms = s_tdata[63:32];
                accepted.rep       = s_tdata[64];
                accepted.task_id   = s_tdata[72:65];
                advance_timer_table(accepted);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_events.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result word: kind %0d slot %0d msg %h task %h %s%b",
                                 m_tuser, m_tdata[3:0], m_tdata[35:4], m_tdata[43:36],
                                 "last ", m_tlast);
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (m_tuser !== want.kind || m_tdata[3:0] !== want.slot ||
                        m_tdata[35:4] !== want.message || m_tdata[43:36] !== want.task_id ||
                        m_tlast !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $write("result mismatch: expected kind %0d slot %0d msg %h task %h ",
                                   want.kind, want.slot, want.message, want.task_id);
                            $display("last %b, got kind %0d slot %0d msg %h task %h last %b",
                                     want.last, m_tuser, m_tdata[3:0], m_tdata[35:4],
                                     m_tdata[43:36], m_tlast);
                        end
                    end
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("message_timer_table_unit test failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus
    initial
    begin
        for (int i = 0; i < POOL_SIZE; i++)
            msg_pool[i] = $urandom;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // sender idles lightly, receiver heavily
        send_idle_pct = 17;
        recv_idle_pct = 70;

        // cancel on an empty table, then a tick with nothing due
        cmd_queue.push_back(make_cmd(CMD_CANCEL, 32'h1234_5678, 32'd0, 1'b0, 8'd0));
        cmd_queue.push_back(make_cmd(CMD_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF));
        // zero period rounds up to one tick; largest period never expires here
        cmd_queue.push_back(make_cmd(CMD_CREATE, 32'h0000_0000, 32'd0, 1'b0, 8'h00));
        cmd_queue.push_back(make_cmd(CMD_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF));
        cmd_queue.push_back(make_cmd(CMD_CREATE, 32'hA5A5_A5A5, 32'd29, 1'b1, 8'h5A));
        cmd_queue.push_back(make_cmd(CMD_CREATE, 32'h5A5A_5A5A, 32'd60, 1'b1, 8'hA5));
        // one-shot and periodic expiries, periodic reload
        cmd_queue.push_back(make_cmd(CMD_TICK, 32'd0, 32'd0, 1'b0, 8'd0));
        cmd_queue.push_back(make_cmd(CMD_TICK, 32'd0, 32'd0, 1'b0, 8'd0));
        cmd_queue.push_back(make_cmd(CMD_CANCEL, 32'hFFFF_FFFF, 32'd0, 1'b0, 8'd0));
        // fill every free slot, then one create too many, then clear
        for (int i = 0; i < 14; i++)
            cmd_queue.push_back(make_cmd(CMD_CREATE, 32'hC000_0000 + 32'(i),
                                         {1'b1, 31'(i)}, 1'(i), 8'(i)));
        cmd_queue.push_back(make_cmd(CMD_CREATE, 32'h0BAD_F00D, 32'd90, 1'b1, 8'h33));
        cmd_queue.push_back(make_cmd(CMD_CLEAR, 32'd0, 32'd0, 1'b0, 8'd0));

        for (int i = 0; i < RAND_WORDS; i++)
            cmd_queue.push_back(random_timer_cmd());
        drain_and_wait();

        // sender idles heavily, receiver lightly
        send_idle_pct = 70;
        recv_idle_pct = 17;
        for (int i = 0; i < RAND_WORDS; i++)
            cmd_queue.push_back(random_timer_cmd());
        drain_and_wait();

        // full rate, with one long receiver hold-off to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_reqs++;
        for (int i = 0; i < RAND_WORDS; i++)
            cmd_queue.push_back(random_timer_cmd());
        drain_and_wait();

        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0 && expected_events.size() == 0)
        begin
            $display("message_timer_table_unit test passed");
        end
        else
        begin
            if (expected_events.size() != 0)
                $display("%0d expected result words never arrived", expected_events.size());
            $display("message_timer_table_unit test failed");
        end
        $finish;
    end

endmodule
